>>> rtl/core/ras_pkg.sv
`timescale 1ns / 1ps

package ras_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 32;
    localparam int SIZE_W     = 25;
    localparam int OFF_W      = 24;
    localparam int BND_W      = 27;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 25'h1000000;

    localparam int DEF_MAX_CHUNKS   = 4;
    localparam int DEF_ADDRESS_BITS = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHUNK_COUNT  = 3'd0,
        REG_CHUNK_SIZE_0 = 3'd1,
        REG_CHUNK_SIZE_1 = 3'd2,
        REG_CHUNK_SIZE_2 = 3'd3,
        REG_CHUNK_SIZE_3 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] request_address;
        logic [LEN_W-1:0]  request_length;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] op_kind;
        logic [IDX_W-1:0]  chunk_index;
        logic [OFF_W-1:0]  chunk_offset;
        logic [SIZE_W-1:0] segment_length;
        logic [LEN_W-1:0]  buffer_offset;
        logic              status;
        logic              last;
    } rsp_t;

    typedef logic [NUM_SLOTS-1:0][SIZE_W-1:0] size_tab_t;
    typedef logic [NUM_SLOTS-1:0][BND_W-1:0]  bnd_tab_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_OFFSET,
        ST_EMIT,
        ST_SINGLE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic locate;
        logic offset;
        logic emit_seg;
        logic emit_single;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic range_err;
        logic seg_final;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/region_access_splitter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    kind, request_address, request_length
// rsp       out        rsp_valid/stall    op_kind .. last, one per segment
// cfg       in         cfg_valid/ready    cfg_index, cfg_data (always ready)
//
// A split request steps through accept, locate and offset, then emits 1..4
// segments one by one through the single segment unit.
// An empty or error request steps through accept, locate, emit.
// A stalled rsp holds the segment unit in place.
// Reset is asynchronous, active low; all chunk sizes and the count reset to 1.
// A size write reaches the chunk end table only after the size table.

module region_access_splitter
    import ras_pkg::*;
#(
    parameter int MAX_CHUNKS   = DEF_MAX_CHUNKS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    size_tab_t        sizes;
    bnd_tab_t         bounds;
    logic [IDX_W-1:0] last_idx;
    dp_cmd_t          cmd;
    dp_status_t       stat;
    ctrl_state_t      state;

    // chunk sizes, clamped count and cumulative chunk ends
    ras_cfg #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sizes     (sizes),
        .bounds    (bounds),
        .last_idx  (last_idx)
    );

    // sequencer: accept, locate, offset, emit
    ras_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd),
        .state     (state)
    );

    // request registers, segment unit and output register
    ras_dp #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sizes     (sizes),
        .bounds    (bounds),
        .last_idx  (last_idx),
        .cmd       (cmd),
        .stat      (stat)
    );

    // an error word is always alone and carries no segment
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> rsp.last && rsp.segment_length == '0)
        else $error("error word not final or not empty");

    // a segment that is not last must run to the end of its chunk
    a_cut_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.status && !rsp.last |->
            SIZE_W'(rsp.chunk_offset) + rsp.segment_length == sizes[rsp.chunk_index])
        else $error("inner segment does not end at a chunk boundary");

    // no segment in a chunk beyond the ones in use
    a_idx_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.chunk_index <= last_idx)
        else $error("segment in an unused chunk");

    // new requests only enter while the sequencer is idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state == ST_LOCATE)
        else $error("request taken outside idle");

endmodule

>>> rtl/core/ras_cfg.sv
`timescale 1ns / 1ps

module ras_cfg
    import ras_pkg::*;
#(
    parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output size_tab_t             sizes,
    output bnd_tab_t              bounds,
    output logic [IDX_W-1:0]      last_idx
);

    localparam int CAP = (MAX_CHUNKS < NUM_SLOTS) ? MAX_CHUNKS : NUM_SLOTS;

    size_tab_t          size_reg, size_next;
    bnd_tab_t           bnd_reg, bnd_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]   cnt_in;
    logic [SIZE_W-1:0]  size_in;
    logic [BND_W-1:0]   acc;

    assign cfg_ready = 1'b1;

    // clamp incoming values once, at write time
    always_comb
    begin
        cnt_in = cfg_data[CNT_W-1:0];
        if (cnt_in == '0)
            cnt_in = CNT_W'(1);
        else if (cnt_in > CNT_W'(CAP))
            cnt_in = CNT_W'(CAP);

        size_in = cfg_data[SIZE_W-1:0];
        if (size_in == '0)
            size_in = SIZE_W'(1);
        else if (size_in > SIZE_MAX)
            size_in = SIZE_MAX;
    end

    always_comb
    begin
        size_next     = size_reg;
        last_idx_next = last_idx_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHUNK_COUNT:  last_idx_next = IDX_W'(cnt_in - CNT_W'(1));
                REG_CHUNK_SIZE_0: size_next[0]  = size_in;
                REG_CHUNK_SIZE_1: size_next[1]  = size_in;
                REG_CHUNK_SIZE_2: size_next[2]  = size_in;
                REG_CHUNK_SIZE_3: size_next[3]  = size_in;
                default: ;
            endcase
        end
    end

    // running end address of each chunk; trails the size table
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            acc         = acc + BND_W'(size_reg[i]);
            bnd_next[i] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                size_reg[i] <= SIZE_W'(1);
                bnd_reg[i]  <= BND_W'(i + 1);
            end
        end
        else
        begin
            last_idx_reg <= last_idx_next;
            size_reg     <= size_next;
            bnd_reg      <= bnd_next;
        end
    end

    assign sizes    = size_reg;
    assign bounds   = bnd_reg;
    assign last_idx = last_idx_reg;

endmodule

>>> rtl/core/ras_ctrl.sv
`timescale 1ns / 1ps

module ras_ctrl
    import ras_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  dp_status_t  stat,
    output dp_cmd_t     cmd,
    output ctrl_state_t state
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                cmd.locate = 1'b1;
                if (stat.zero_len || stat.range_err)
                    state_next = ST_SINGLE;
                else
                    state_next = ST_OFFSET;
            end
            ST_OFFSET:
            begin
                cmd.offset = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_seg = 1'b1;
                    if (stat.seg_final)
                        state_next = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign state = state_reg;

endmodule

>>> rtl/core/ras_dp.sv
`timescale 1ns / 1ps

module ras_dp
    import ras_pkg::*;
#(
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    output rsp_t             rsp,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  size_tab_t        sizes,
    input  bnd_tab_t         bounds,
    input  logic [IDX_W-1:0] last_idx,
    input  dp_cmd_t          cmd,
    output dp_status_t       stat
);

    // end + 1 must not exceed 2^ADDRESS_BITS; no limit from ADDRESS_BITS 33 up
    localparam logic [ADDR_W+1:0] SPACE_LIM =
        (ADDRESS_BITS < ADDR_W + 1) ? ((ADDR_W+2)'(1) << ADDRESS_BITS) : '1;

    logic [KIND_W-1:0] kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  remain_reg;
    logic [LEN_W-1:0]  done_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              err_reg;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [ADDR_W:0]   end_excl;
    logic              range_err;
    logic              zero_len;
    logic [IDX_W-1:0]  idx_found;
    logic              found;
    logic [BND_W-1:0]  start_sel;
    logic [BND_W-1:0]  off_full;
    logic [SIZE_W-1:0] room;
    logic              take_rest;
    logic [SIZE_W-1:0] seg;
    logic              seg_final;

    // locate: range check and first chunk whose end lies past the start
    always_comb
    begin
        end_excl  = {1'b0, addr_reg} + {1'b0, len_reg};
        zero_len  = (len_reg == '0);
        range_err = ({1'b0, end_excl} > SPACE_LIM) ||
                    (end_excl > (ADDR_W+1)'(bounds[last_idx]));
        idx_found = last_idx;
        found     = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!found && (IDX_W'(i) == last_idx ||
                           addr_reg < ADDR_W'(bounds[i])))
            begin
                idx_found = IDX_W'(i);
                found     = 1'b1;
            end
        end
    end

    // offset: start of chunk is the end of the one before
    always_comb
    begin
        start_sel = (idx_reg == '0) ? '0 : bounds[idx_reg - IDX_W'(1)];
        off_full  = addr_reg[BND_W-1:0] - start_sel;
    end

    // segment: what is left of this chunk against what is left of the request
    always_comb
    begin
        room      = sizes[idx_reg] - SIZE_W'(off_reg);
        take_rest = (LEN_W'(room) >= remain_reg);
        seg       = take_rest ? remain_reg[SIZE_W-1:0] : room;
        seg_final = take_rest || (idx_reg == last_idx);
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.emit_seg)
        begin
            rsp_next.op_kind        = kind_reg;
            rsp_next.chunk_index    = idx_reg;
            rsp_next.chunk_offset   = off_reg;
            rsp_next.segment_length = seg;
            rsp_next.buffer_offset  = done_reg;
            rsp_next.status         = 1'b0;
            rsp_next.last           = seg_final;
            rsp_valid_next          = 1'b1;
        end
        else if (cmd.emit_single)
        begin
            rsp_next         = '0;
            rsp_next.op_kind = kind_reg;
            rsp_next.status  = err_reg;
            rsp_next.last    = 1'b1;
            rsp_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.capture)
        begin
            kind_reg <= req.kind;
            addr_reg <= req.request_address;
            len_reg  <= req.request_length;
        end
        if (cmd.locate)
        begin
            idx_reg    <= idx_found;
            err_reg    <= range_err && !zero_len;
            remain_reg <= len_reg;
            done_reg   <= '0;
        end
        if (cmd.offset)
            off_reg <= off_full[OFF_W-1:0];
        if (cmd.emit_seg)
        begin
            remain_reg <= remain_reg - LEN_W'(seg);
            done_reg   <= done_reg + LEN_W'(seg);
            off_reg    <= '0;
            idx_reg    <= idx_reg + IDX_W'(1);
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign stat.zero_len  = zero_len;
    assign stat.range_err = range_err;
    assign stat.seg_final = seg_final;
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

endmodule
